>>> hdl/usbidm_pkg.sv
// Shared types, constants and codes for the USB device-ID match table.
package usbidm_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] ST_LOADED  = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_MATCH   = 2'd2;
    localparam logic [1:0] ST_NOMATCH = 2'd3;

    localparam int FL_VENDOR  = 0;
    localparam int FL_PRODUCT = 1;
    localparam int FL_CODE0   = 4;
    localparam int NUM_CODES  = 6;

    typedef struct packed {
        logic [9:0]  flags;
        logic [15:0] vendor_id;
        logic [15:0] product_id;
        logic [47:0] codes;
        logic [15:0] module_num;
    } t_entry;

    typedef struct packed {
        logic [15:0] vendor_id;
        logic [15:0] product_id;
        logic [47:0] codes;
    } t_query;

    typedef struct packed {
        logic        hit;
        logic [15:0] module_num;
    } t_token;

    typedef struct packed {
        logic load;
        logic capture;
        logic advance;
    } t_cell_ctrl;

endpackage

>>> hdl/usbidm_in_if.sv
// Request channel carrying a table load or a device identity query.
interface usbidm_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [9:0]  flags;
    logic [15:0] vendor_id;
    logic [15:0] product_id;
    logic [7:0]  dev_class;
    logic [7:0]  dev_subclass;
    logic [7:0]  dev_protocol;
    logic [7:0]  intf_class;
    logic [7:0]  intf_subclass;
    logic [7:0]  intf_protocol;
    logic [15:0] module_num;

    modport source (
        output valid, op, flags, vendor_id, product_id, dev_class, dev_subclass,
               dev_protocol, intf_class, intf_subclass, intf_protocol, module_num,
        input  ready
    );
    modport sink (
        input  valid, op, flags, vendor_id, product_id, dev_class, dev_subclass,
               dev_protocol, intf_class, intf_subclass, intf_protocol, module_num,
        output ready
    );
endinterface

>>> hdl/usbidm_out_if.sv
// Result channel carrying load status and match results.
interface usbidm_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] matched_module;
    logic        last;

    modport source (output valid, status, matched_module, last, input ready);
    modport sink (input valid, status, matched_module, last, output ready);
endinterface

>>> hdl/usb_id_masked_match_table_core.sv
// Top level: a row of entry cells, newest first, walked by a token shift toward cell zero.
// A load's status is registered and presented in the cycle after acceptance.
// A query captures all cell comparisons together, then shifts one entry per cycle while
// the output is free; the token shift sets this rate.
// Results are delayed by one match so that the final one can carry last.
// Synchronous active-low reset empties the table and idles the walker; no clearing pass.
module usb_id_masked_match_table_core
    import usbidm_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    usbidm_in_if.sink     i_req,
    usbidm_out_if.source  o_rsp
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_WALK  = 2'd1;
    localparam logic [1:0] S_FLUSH = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_left, n_left;
    logic             r_pend, n_pend;
    logic [15:0]      r_pend_mod, n_pend_mod;
    logic             r_out_valid, n_out_valid;
    logic [1:0]       r_out_status, n_out_status;
    logic [15:0]      r_out_module, n_out_module;
    logic             r_out_last, n_out_last;

    logic       w_out_free;
    logic       w_accept;
    logic       w_full;
    t_cell_ctrl w_ctrl;
    t_entry     w_new;
    t_query     w_query;
    t_entry     w_ent [TABLE_DEPTH];
    t_token     w_tok [TABLE_DEPTH];

    assign w_out_free = !r_out_valid || o_rsp.ready;
    assign i_req.ready = (r_state == S_IDLE) && w_out_free;
    assign w_accept   = i_req.valid && i_req.ready;
    assign w_full     = (r_count == CNT_W'(TABLE_DEPTH));

    assign w_query.vendor_id  = i_req.vendor_id;
    assign w_query.product_id = i_req.product_id;
    assign w_query.codes      = {i_req.dev_class, i_req.dev_subclass, i_req.dev_protocol,
                                 i_req.intf_class, i_req.intf_subclass, i_req.intf_protocol};
    assign w_new.flags        = i_req.flags;
    assign w_new.vendor_id    = i_req.vendor_id;
    assign w_new.product_id   = i_req.product_id;
    assign w_new.codes        = w_query.codes;
    assign w_new.module_num   = i_req.module_num;

    for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
        t_entry w_in_ent;
        t_token w_in_tok;
        if (k == 0) begin : g_head
            assign w_in_ent = w_new;
        end else begin : g_body
            assign w_in_ent = w_ent[k-1];
        end
        if (k == TABLE_DEPTH - 1) begin : g_tail
            assign w_in_tok = '0;
        end else begin : g_link
            assign w_in_tok = w_tok[k+1];
        end
        usbidm_cell u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (w_ctrl),
            .i_entry    (w_in_ent),
            .i_query    (w_query),
            .i_tok_next (w_in_tok),
            .o_entry    (w_ent[k]),
            .o_tok      (w_tok[k])
        );
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_left       = r_left;
        n_pend       = r_pend;
        n_pend_mod   = r_pend_mod;
        n_out_valid  = o_rsp.ready ? 1'b0 : r_out_valid;
        n_out_status = r_out_status;
        n_out_module = r_out_module;
        n_out_last   = r_out_last;
        w_ctrl       = '0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_req.op == OP_LOAD) begin
                        n_out_valid  = 1'b1;
                        n_out_module = '0;
                        n_out_last   = 1'b1;
                        if (w_full) begin
                            n_out_status = ST_FULL;
                        end else begin
                            n_out_status = ST_LOADED;
                            w_ctrl.load  = 1'b1;
                            n_count      = r_count + CNT_W'(1);
                        end
                    end else begin
                        w_ctrl.capture = 1'b1;
                        n_left         = r_count;
                        n_pend         = 1'b0;
                        n_state        = (r_count == '0) ? S_FLUSH : S_WALK;
                    end
                end
            end
            S_WALK: begin
                if (w_out_free) begin
                    w_ctrl.advance = 1'b1;
                    n_left         = r_left - CNT_W'(1);
                    if (w_tok[0].hit) begin
                        if (r_pend) begin
                            n_out_valid  = 1'b1;
                            n_out_status = ST_MATCH;
                            n_out_module = r_pend_mod;
                            n_out_last   = 1'b0;
                        end
                        n_pend     = 1'b1;
                        n_pend_mod = w_tok[0].module_num;
                    end
                    if (r_left == CNT_W'(1)) begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_FLUSH: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_last  = 1'b1;
                    if (r_pend) begin
                        n_out_status = ST_MATCH;
                        n_out_module = r_pend_mod;
                    end else begin
                        n_out_status = ST_NOMATCH;
                        n_out_module = '0;
                    end
                    n_pend  = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_left      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_left      <= n_left;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
        r_pend_mod   <= n_pend_mod;
        r_out_status <= n_out_status;
        r_out_module <= n_out_module;
        r_out_last   <= n_out_last;
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_out_status;
    assign o_rsp.matched_module = r_out_module;
    assign o_rsp.last           = r_out_last;

endmodule

>>> hdl/usbidm_cell.sv
// One table cell: holds an entry, compares it to a query and shifts its match token.
module usbidm_cell
    import usbidm_pkg::*;
(
    input  logic       i_clk,
    input  t_cell_ctrl i_ctrl,
    input  t_entry     i_entry,
    input  t_query     i_query,
    input  t_token     i_tok_next,
    output t_entry     o_entry,
    output t_token     o_tok
);

    t_entry r_entry;
    t_token r_tok;
    logic   w_match;

    always_comb begin
        w_match = (!r_entry.flags[FL_VENDOR] || (r_entry.vendor_id == i_query.vendor_id))
               && (!r_entry.flags[FL_PRODUCT] || (r_entry.product_id == i_query.product_id));
        for (int b = 0; b < NUM_CODES; b++) begin
            if (r_entry.flags[FL_CODE0 + b] &&
                (r_entry.codes[40 - 8 * b +: 8] != i_query.codes[40 - 8 * b +: 8])) begin
                w_match = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_entry <= i_entry;
        end
        if (i_ctrl.capture) begin
            r_tok.hit        <= w_match;
            r_tok.module_num <= r_entry.module_num;
        end else if (i_ctrl.advance) begin
            r_tok <= i_tok_next;
        end
    end

    assign o_entry = r_entry;
    assign o_tok   = r_tok;

endmodule
